// ----- rtl/slrt_pkg.sv -----
// Shared types and constants of the slice reassembly tracker.
// Used by slrt_cell, slrt_ctrl and slice_reassembly_tracker; depends on nothing.
package slrt_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam int NODE_W  = 16;
    localparam int MSG_W   = 32;
    localparam int SLICE_W = 16;
    localparam int BYTES_W = 24;
    localparam int DELAY_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

    typedef enum logic [STAT_W-1:0] {
        STAT_NEW     = 2'd0,
        STAT_UPDATED = 2'd1,
        STAT_DROPPED = 2'd2
    } status_t;

    // lookup token walking the cell chain
    typedef struct packed {
        logic               active;
        logic [NODE_W-1:0]  sender;
        logic [MSG_W-1:0]   message;
        logic               hit;
        logic               free;
        logic [NODE_W-1:0]  dest;
        logic [BYTES_W-1:0] bytes;
        logic [DELAY_W-1:0] delay;
        logic               done;
    } probe_t;

    // write command broadcast to all cells
    typedef struct packed {
        logic               we;
        logic               alloc;
        logic               clear;
        logic [NODE_W-1:0]  sender;
        logic [MSG_W-1:0]   message;
        logic [NODE_W-1:0]  dest;
        logic [BYTES_W-1:0] bytes;
        logic [DELAY_W-1:0] delay;
        logic               done;
    } cmd_t;

endpackage

// ----- rtl/slice_reassembly_tracker.sv -----
// Slice reassembly tracker: one slice in, one result word out, after a lookup
// across every table entry. Depends on slrt_pkg, slrt_cell and slrt_ctrl.
//
// The table is a row of TABLE_ENTRIES cells, one entry each, keyed by sender and
// message id. A lookup token enters the first cell when a slice is taken and moves
// one cell per cycle, picking up the first matching entry and the first free one.
// The sequencer then writes the single chosen cell, if any, and forms the result
// word. A slice is taken only while the sequencer is idle: the token is launched,
// walks down the chain, the lookup is captured and the entry is written before the
// next slice is taken. The result word turns valid as its entry is written. The
// next slice is taken while a finished result still waits at the output; if that
// word is still waiting when the next write is due, the write, and the slice after
// it, hold until the word is taken. batch_end clears every entry in the same cycle
// as the write. Entry fields other than the valid and finished bits have no reset.
module slice_reassembly_tracker
    import slrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [NODE_W-1:0]  sender_id,
    input  logic [MSG_W-1:0]   message_id,
    input  logic [NODE_W-1:0]  receiver_id,
    input  logic [SLICE_W-1:0] slice_size,
    input  logic [BYTES_W-1:0] total_size,
    input  logic [DELAY_W-1:0] slice_delay,
    input  logic               batch_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [NODE_W-1:0]  entry_receiver,
    output logic [BYTES_W-1:0] gathered_size,
    output logic [DELAY_W-1:0] worst_delay,
    output logic               finished,
    output logic [STAT_W-1:0]  status
);

    probe_t                   probe_chain [0:TABLE_ENTRIES];
    cmd_t                     cmd;
    logic [TABLE_ENTRIES-1:0] sel_hit_vec;
    logic [TABLE_ENTRIES-1:0] sel_free_vec;

    slrt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sender_id      (sender_id),
        .message_id     (message_id),
        .receiver_id    (receiver_id),
        .slice_size     (slice_size),
        .total_size     (total_size),
        .slice_delay    (slice_delay),
        .batch_end      (batch_end),
        .probe_head     (probe_chain[0]),
        .probe_tail     (probe_chain[TABLE_ENTRIES]),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_receiver (entry_receiver),
        .gathered_size  (gathered_size),
        .worst_delay    (worst_delay),
        .finished       (finished),
        .status         (status)
    );

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        slrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (probe_chain[i]),
            .probe_out (probe_chain[i+1]),
            .cmd       (cmd),
            .sel_hit   (sel_hit_vec[i]),
            .sel_free  (sel_free_vec[i])
        );
    end

    a_one_hit_target: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.we && !cmd.alloc) |-> ($countones(sel_hit_vec) == 1))
        else $error("entry update without exactly one matching cell");

    a_one_alloc_target: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.we && cmd.alloc) |-> ($countones(sel_free_vec) == 1))
        else $error("allocation without exactly one free cell selected");

    a_tail_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        probe_chain[TABLE_ENTRIES].active |-> !in_ready)
        else $error("lookup token reached chain end while idle");

    a_hit_before_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> ($countones(sel_hit_vec | sel_free_vec) <= 2))
        else $error("more than one cell selected per kind after batch end");

endmodule

// ----- rtl/slrt_cell.sv -----
// One table entry of the slice reassembly tracker, with its stage of the lookup chain.
// Depends on slrt_pkg.
module slrt_cell
    import slrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  probe_t probe_in,
    output probe_t probe_out,
    input  cmd_t   cmd,
    output logic   sel_hit,
    output logic   sel_free
);

    logic               valid_reg;
    logic               done_reg;
    logic               sel_hit_reg;
    logic               sel_free_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic [NODE_W-1:0]  sender_reg;
    logic [MSG_W-1:0]   message_reg;
    logic [NODE_W-1:0]  dest_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               match;
    logic               take_free;
    logic               wr_hit;
    logic               wr_alloc;

    assign match = probe_in.active && valid_reg && !probe_in.hit
                   && (sender_reg == probe_in.sender) && (message_reg == probe_in.message);
    assign take_free = probe_in.active && !valid_reg && !probe_in.free;

    assign wr_hit   = cmd.we && !cmd.alloc && sel_hit_reg;
    assign wr_alloc = cmd.we && cmd.alloc && sel_free_reg;

    always_comb
    begin
        probe_next = probe_in;
        if (match)
        begin
            probe_next.hit   = 1'b1;
            probe_next.dest  = dest_reg;
            probe_next.bytes = bytes_reg;
            probe_next.delay = delay_reg;
            probe_next.done  = done_reg;
        end
        if (take_free)
        begin
            probe_next.free = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg    <= '0;
            valid_reg    <= 1'b0;
            done_reg     <= 1'b0;
            sel_hit_reg  <= 1'b0;
            sel_free_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (probe_in.active)
            begin
                sel_hit_reg  <= match;
                sel_free_reg <= take_free;
            end
            if (wr_alloc)
            begin
                valid_reg <= 1'b1;
            end
            if (wr_hit || wr_alloc)
            begin
                done_reg <= cmd.done;
            end
            // drop the whole table after the slice
            if (cmd.clear)
            begin
                valid_reg <= 1'b0;
                done_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_alloc)
        begin
            sender_reg  <= cmd.sender;
            message_reg <= cmd.message;
            dest_reg    <= cmd.dest;
        end
        if (wr_hit || wr_alloc)
        begin
            bytes_reg <= cmd.bytes;
            delay_reg <= cmd.delay;
        end
    end

    assign probe_out = probe_reg;
    assign sel_hit   = sel_hit_reg;
    assign sel_free  = sel_free_reg;

endmodule

// ----- rtl/slrt_ctrl.sv -----
// Sequencer of the slice reassembly tracker: takes slices, launches the lookup,
// forms the entry update and the result word. Depends on slrt_pkg.
module slrt_ctrl
    import slrt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SLICE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [NODE_W-1:0]  sender_id,
    input  logic [MSG_W-1:0]   message_id,
    input  logic [NODE_W-1:0]  receiver_id,
    input  logic [SLICE_W-1:0] slice_size,
    input  logic [BYTES_W-1:0] total_size,
    input  logic [DELAY_W-1:0] slice_delay,
    input  logic               batch_end,
    output probe_t             probe_head,
    input  probe_t             probe_tail,
    output cmd_t               cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [NODE_W-1:0]  entry_receiver,
    output logic [BYTES_W-1:0] gathered_size,
    output logic [DELAY_W-1:0] worst_delay,
    output logic               finished,
    output logic [STAT_W-1:0]  status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SLICE_W-1:0] header_length_reg;
    logic               head_active_reg;
    logic               head_active_next;
    logic [NODE_W-1:0]  snd_reg;
    logic [MSG_W-1:0]   msg_reg;
    logic [NODE_W-1:0]  rcv_reg;
    logic [SLICE_W-1:0] payload_reg;
    logic [BYTES_W-1:0] total_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               last_reg;
    logic               res_hit_reg;
    logic               res_free_reg;
    logic [NODE_W-1:0]  res_dest_reg;
    logic [BYTES_W-1:0] res_bytes_reg;
    logic [DELAY_W-1:0] res_delay_reg;
    logic               res_done_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [NODE_W-1:0]  out_dest_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic [DELAY_W-1:0] out_delay_reg;
    logic               out_done_reg;
    status_t            out_status_reg;

    logic               accept;
    logic               scan_done;
    logic               slot_free;
    logic               fire;
    logic [SLICE_W-1:0] payload_calc;
    logic [BYTES_W:0]   sum_wide;
    logic [BYTES_W-1:0] sum_sat;
    logic [BYTES_W-1:0] new_bytes;
    logic [DELAY_W-1:0] new_delay;
    logic               new_done;
    status_t            new_status;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign scan_done = (state_reg == ST_SCAN) && probe_tail.active;
    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = (state_reg == ST_WRITE) && slot_free;

    assign payload_calc = (slice_size > header_length_reg) ? (slice_size - header_length_reg)
                                                           : '0;

    assign sum_wide = {1'b0, probe_tail.bytes} + {{(BYTES_W + 1 - SLICE_W){1'b0}}, payload_reg};
    assign sum_sat  = sum_wide[BYTES_W] ? BYTES_MAX : sum_wide[BYTES_W-1:0];

    always_comb
    begin
        if (probe_tail.hit)
        begin
            new_bytes  = sum_sat;
            new_delay  = (probe_tail.delay < delay_reg) ? delay_reg : probe_tail.delay;
            new_done   = probe_tail.done || (sum_sat == total_reg);
            new_status = STAT_UPDATED;
        end
        else if (probe_tail.free)
        begin
            new_bytes  = {{(BYTES_W - SLICE_W){1'b0}}, payload_reg};
            new_delay  = delay_reg;
            new_done   = (new_bytes == total_reg);
            new_status = STAT_NEW;
        end
        else
        begin
            new_bytes  = '0;
            new_delay  = '0;
            new_done   = 1'b0;
            new_status = STAT_DROPPED;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        head_active_next = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    head_active_next = 1'b1;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (probe_tail.active)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            header_length_reg <= SLICE_W'(40);
            head_active_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_active_reg <= head_active_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                header_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snd_reg     <= sender_id;
            msg_reg     <= message_id;
            rcv_reg     <= receiver_id;
            payload_reg <= payload_calc;
            total_reg   <= total_size;
            delay_reg   <= slice_delay;
            last_reg    <= batch_end;
        end
        if (scan_done)
        begin
            res_hit_reg    <= probe_tail.hit;
            res_free_reg   <= probe_tail.free;
            res_dest_reg   <= probe_tail.hit ? probe_tail.dest
                                             : (probe_tail.free ? rcv_reg : '0);
            res_bytes_reg  <= new_bytes;
            res_delay_reg  <= new_delay;
            res_done_reg   <= new_done;
            res_status_reg <= new_status;
        end
        if (fire)
        begin
            out_dest_reg   <= res_dest_reg;
            out_bytes_reg  <= res_bytes_reg;
            out_delay_reg  <= res_delay_reg;
            out_done_reg   <= res_done_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        probe_head         = '0;
        probe_head.active  = head_active_reg;
        probe_head.sender  = snd_reg;
        probe_head.message = msg_reg;
    end

    always_comb
    begin
        cmd.we      = fire && (res_hit_reg || res_free_reg);
        cmd.alloc   = !res_hit_reg;
        cmd.clear   = fire && last_reg;
        cmd.sender  = snd_reg;
        cmd.message = msg_reg;
        cmd.dest    = rcv_reg;
        cmd.bytes   = res_bytes_reg;
        cmd.delay   = res_delay_reg;
        cmd.done    = res_done_reg;
    end

    assign out_valid      = out_valid_reg;
    assign entry_receiver = out_dest_reg;
    assign gathered_size  = out_bytes_reg;
    assign worst_delay    = out_delay_reg;
    assign finished       = out_done_reg;
    assign status         = out_status_reg;

endmodule
